>>> sv/bpc_pkg.sv
// shared types and constants of the button press pattern classifier
// no dependencies; every other file refers to it by scoped names
package bpc_pkg;

   localparam int NUM_BUTTONS   = 4;
   localparam int BTN_IDX_BITS  = 2;
   localparam int COUNT_BITS    = 4;
   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [15:0] WINDOW_TICKS_RESET   = 16'd100;
   localparam logic [7:0]  LONG_THRESHOLD_RESET = 8'd20;
   localparam logic [15:0] SHORT_LIMITS_RESET   = 16'h2233;
   localparam logic [15:0] LONG_LIMITS_RESET    = 16'h1111;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_WINDOW_TICKS   = 4'd0,
      REG_LONG_THRESHOLD = 4'd1,
      REG_SHORT_LIMITS   = 4'd2,
      REG_LONG_LIMITS    = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0] window_ticks;
      logic [7:0]  long_threshold;
      logic [15:0] short_limits;
      logic [15:0] long_limits;
   } cfg_regs_type;

   typedef struct packed {
      logic [7:0]            long_threshold;
      logic [COUNT_BITS-1:0] short_limit;
      logic [COUNT_BITS-1:0] long_limit;
   } lane_cfg_type;

   typedef struct packed {
      logic                  evt;
      logic [COUNT_BITS-1:0] short_count;
      logic [COUNT_BITS-1:0] long_count;
   } lane_status_type;

endpackage

>>> sv/bpc_if.sv
// valid/ready channel interfaces: scan tick in, event word out, register write
// depends on bpc_pkg
interface bpc_req_if;
   logic                               valid;
   logic                               ready;
   logic [bpc_pkg::NUM_BUTTONS-1:0]    pressed_mask;
   modport source (output valid, output pressed_mask, input ready);
   modport sink (input valid, input pressed_mask, output ready);
endinterface

interface bpc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [bpc_pkg::BTN_IDX_BITS-1:0]   button_index;
   logic [bpc_pkg::COUNT_BITS-1:0]     short_presses;
   logic [bpc_pkg::COUNT_BITS-1:0]     long_presses;
   logic                               last;
   modport source (output valid, output button_index, output short_presses,
                   output long_presses, output last, input ready);
   modport sink (input valid, input button_index, input short_presses,
                 input long_presses, input last, output ready);
endinterface

interface bpc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [bpc_pkg::CSR_IDX_BITS-1:0]   index;
   logic [bpc_pkg::CSR_DATA_BITS-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/bpc_regs.sv
// configuration registers: window length, long threshold, per-button limits
// depends on bpc_pkg and bpc_csr_if
module bpc_regs (
   input  logic                  clock,
   input  logic                  reset,
   bpc_csr_if.sink               csr_chan,
   output bpc_pkg::cfg_regs_type cfg
);

   bpc_pkg::cfg_regs_type cfg_ff;
   bpc_pkg::cfg_regs_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            bpc_pkg::REG_WINDOW_TICKS:   cfg_in.window_ticks   = csr_chan.data;
            bpc_pkg::REG_LONG_THRESHOLD: cfg_in.long_threshold = csr_chan.data[7:0];
            bpc_pkg::REG_SHORT_LIMITS:   cfg_in.short_limits   = csr_chan.data;
            bpc_pkg::REG_LONG_LIMITS:    cfg_in.long_limits    = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ticks   <= bpc_pkg::WINDOW_TICKS_RESET;
         cfg_ff.long_threshold <= bpc_pkg::LONG_THRESHOLD_RESET;
         cfg_ff.short_limits   <= bpc_pkg::SHORT_LIMITS_RESET;
         cfg_ff.long_limits    <= bpc_pkg::LONG_LIMITS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> sv/bpc_lane.sv
// one button lane: up/down/after-long phases, window timer, press counters
// depends on bpc_pkg
module bpc_lane #(
   parameter int TIMER_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     pressed,
   input  logic [TIMER_BITS-1:0]    window,
   input  bpc_pkg::lane_cfg_type    cfg,
   output bpc_pkg::lane_status_type status
);

   typedef enum logic [1:0] {PH_UP, PH_DN, PH_AL} phase_type;

   phase_type                         phase_ff, phase_in;
   logic [7:0]                        hold_ff, hold_in;
   logic [TIMER_BITS-1:0]             timer_ff, timer_in;
   logic [bpc_pkg::COUNT_BITS-1:0]    short_ff, short_in;
   logic [bpc_pkg::COUNT_BITS-1:0]    long_ff, long_in;
   logic                              in_window_ff, in_window_in;
   logic                              finished_ff, finished_in;
   logic                              reported_ff, reported_in;

   logic                              do_scan;
   logic [TIMER_BITS-1:0]             t_cur;
   logic [bpc_pkg::COUNT_BITS-1:0]    short_sat, long_sat;

   assign short_sat = (short_ff != bpc_pkg::COUNT_MAX) ? short_ff + 1'b1 : short_ff;
   assign long_sat  = (long_ff != bpc_pkg::COUNT_MAX) ? long_ff + 1'b1 : long_ff;

   assign status.evt         = step && finished_ff && !reported_ff;
   assign status.short_count = short_ff;
   assign status.long_count  = long_ff;

   always_comb begin
      phase_in     = phase_ff;
      hold_in      = hold_ff;
      timer_in     = timer_ff;
      short_in     = short_ff;
      long_in      = long_ff;
      in_window_in = in_window_ff;
      finished_in  = finished_ff;
      reported_in  = reported_ff;
      do_scan      = 1'b0;
      t_cur        = timer_ff;
      if (step) begin
         if (finished_ff) begin
            if (!reported_ff) begin
               reported_in  = 1'b1;
               timer_in     = window;
               in_window_in = 1'b0;
            end else if (timer_ff != '0) begin
               timer_in = timer_ff - 1'b1;
            end else begin
               phase_in     = PH_UP;
               hold_in      = '0;
               timer_in     = '0;
               short_in     = '0;
               long_in      = '0;
               in_window_in = 1'b0;
               finished_in  = 1'b0;
               reported_in  = 1'b0;
            end
         end else if (in_window_ff) begin
            if (timer_ff != '0) begin
               t_cur    = timer_ff - 1'b1;
               timer_in = t_cur;
               do_scan  = 1'b1;
            end else begin
               finished_in = 1'b1;
            end
         end else begin
            do_scan = 1'b1;
         end
      end
      if (do_scan) begin
         unique case (phase_ff)
            PH_UP: begin
               if (pressed) begin
                  phase_in = PH_DN;
                  hold_in  = '0;
                  if (!in_window_ff) begin
                     in_window_in = 1'b1;
                     timer_in     = window;
                  end
               end
            end
            PH_DN: begin
               timer_in = t_cur + 1'b1;
               if (pressed) begin
                  if (hold_ff < cfg.long_threshold) begin
                     hold_in = hold_ff + 1'b1;
                  end else begin
                     phase_in = PH_AL;
                  end
               end else begin
                  phase_in = PH_UP;
                  hold_in  = '0;
                  short_in = short_sat;
                  if (short_sat >= cfg.short_limit) begin
                     finished_in  = 1'b1;
                     in_window_in = 1'b0;
                     timer_in     = '0;
                  end
               end
            end
            PH_AL: begin
               if (pressed) begin
                  timer_in = t_cur + 1'b1;
               end else begin
                  phase_in = PH_UP;
                  hold_in  = '0;
                  long_in  = long_sat;
                  if (long_sat >= cfg.long_limit) begin
                     finished_in  = 1'b1;
                     in_window_in = 1'b0;
                     timer_in     = '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_UP;
         hold_ff      <= '0;
         timer_ff     <= '0;
         short_ff     <= '0;
         long_ff      <= '0;
         in_window_ff <= 1'b0;
         finished_ff  <= 1'b0;
         reported_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hold_ff      <= hold_in;
         timer_ff     <= timer_in;
         short_ff     <= short_in;
         long_ff      <= long_in;
         in_window_ff <= in_window_in;
         finished_ff  <= finished_in;
         reported_ff  <= reported_in;
      end
   end

   a_evt_marks_reported: assert property (@(posedge clock) disable iff (reset)
      status.evt |=> reported_ff && finished_ff)
      else $error("lane event not marked reported");

   a_reported_needs_finished: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> finished_ff)
      else $error("lane reported without finished window");

   a_pressed_phase_in_window: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_UP) |-> (in_window_ff || finished_ff))
      else $error("lane held outside any window");

endmodule

>>> sv/bpc_merge.sv
// merge stage: collects lane events of one tick, sends them one word a cycle while rsp_chan.ready is high
// depends on bpc_pkg and bpc_rsp_if
module bpc_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  bpc_pkg::lane_status_type status [bpc_pkg::NUM_BUTTONS],
   output logic                     take_ready,
   bpc_rsp_if.source                rsp_chan
);

   logic [bpc_pkg::NUM_BUTTONS-1:0]  pend_ff, pend_in;
   logic [bpc_pkg::NUM_BUTTONS-1:0]  evt_mask, pend_rest;
   logic [bpc_pkg::BTN_IDX_BITS-1:0] sel;
   logic                             load;

   logic                             valid_ff, valid_in;
   logic [bpc_pkg::BTN_IDX_BITS-1:0] idx_ff, idx_in;
   logic [bpc_pkg::COUNT_BITS-1:0]   short_ff, short_in;
   logic [bpc_pkg::COUNT_BITS-1:0]   long_ff, long_in;
   logic                             last_ff, last_in;

   always_comb begin
      for (int i = 0; i < bpc_pkg::NUM_BUTTONS; i++) begin
         evt_mask[i] = status[i].evt;
      end
      sel = '0;
      for (int i = bpc_pkg::NUM_BUTTONS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel = bpc_pkg::BTN_IDX_BITS'(i);
         end
      end
      pend_rest      = pend_ff;
      pend_rest[sel] = 1'b0;
   end

   assign take_ready = (pend_ff == '0);
   assign load = (pend_ff != '0) && (!valid_ff || rsp_chan.ready);

   always_comb begin
      pend_in  = pend_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      short_in = short_ff;
      long_in  = long_ff;
      last_in  = last_ff;
      if (valid_ff && rsp_chan.ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         pend_in = evt_mask;
      end else if (load) begin
         pend_in  = pend_rest;
         valid_in = 1'b1;
         idx_in   = sel;
         short_in = status[sel].short_count;
         long_in  = status[sel].long_count;
         last_in  = (pend_rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
      idx_ff   <= idx_in;
      short_ff <= short_in;
      long_ff  <= long_in;
      last_ff  <= last_in;
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.button_index  = idx_ff;
   assign rsp_chan.short_presses = short_ff;
   assign rsp_chan.long_presses  = long_ff;
   assign rsp_chan.last          = last_ff;

   a_load_drops_one: assert property (@(posedge clock) disable iff (reset)
      load |=> ($countones(pend_ff) == $past($countones(pend_ff)) - 1))
      else $error("merge did not retire exactly one pending event");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (load && (pend_rest == '0)) |=> (pend_ff == '0) && last_ff && valid_ff)
      else $error("final word of a tick not flagged last");

   a_no_accept_while_pending: assert property (@(posedge clock) disable iff (reset)
      accept |-> !load)
      else $error("tick accepted while events still pending");

endmodule

>>> sv/button_press_pattern_classifier_core.sv
// Button press pattern classifier: four button lanes, a merge stage, config registers.
// One scan tick word on req_chan steps every button lane at once. A tick that causes no
// event leaves req_chan.ready high, so ticks may arrive back to back. A tick that reports
// finished windows (up to four) holds req_chan.ready low until the merge stage has moved
// the events, lowest button first, one per cycle unless rsp_chan.ready is low, into the
// output register; the last word of the tick has last set. A tick's events are first
// registered in the pending mask, then loaded into the output register. Register
// writes on csr_chan are always taken, as ready is tied high, and are meant for an idle block.
// Depends on bpc_pkg, the channel interfaces, bpc_regs, bpc_lane and bpc_merge.
module button_press_pattern_classifier_core #(
   parameter int TIMER_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   bpc_req_if.sink   req_chan,
   bpc_rsp_if.source rsp_chan,
   bpc_csr_if.sink   csr_chan
);

   bpc_pkg::cfg_regs_type    cfg;
   bpc_pkg::lane_status_type status [bpc_pkg::NUM_BUTTONS];
   logic                     take_ready;
   logic                     accept;
   logic [TIMER_BITS-1:0]    window;

   assign req_chan.ready = take_ready;
   assign accept = req_chan.valid && take_ready;
   assign window = TIMER_BITS'(cfg.window_ticks);

   bpc_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   for (genvar b = 0; b < bpc_pkg::NUM_BUTTONS; b++) begin : g_lane
      bpc_pkg::lane_cfg_type lane_cfg;

      assign lane_cfg.long_threshold = cfg.long_threshold;
      assign lane_cfg.short_limit    = cfg.short_limits[b*4 +: 4];
      assign lane_cfg.long_limit     = cfg.long_limits[b*4 +: 4];

      bpc_lane #(
         .TIMER_BITS (TIMER_BITS)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .step    (accept),
         .pressed (req_chan.pressed_mask[b]),
         .window  (window),
         .cfg     (lane_cfg),
         .status  (status[b])
      );
   end

   bpc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .status     (status),
      .take_ready (take_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> tb/button_press_pattern_classifier_core_test.sv
// self-checking bench for button_press_pattern_classifier_core: random scan ticks,
// stalls on both channels, register settings per phase, events checked word by word
// depends on bpc_pkg, the channel interfaces and the core with its submodules
module button_press_pattern_classifier_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIMER_W = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_PRINTED = 60;
   localparam logic [bpc_pkg::CSR_IDX_BITS-1:0] REG_UNUSED = 4'd9;

   typedef enum logic [1:0] {PH_UP, PH_DOWN, PH_AFTER_LONG} press_phase_type;

   typedef struct packed {
      logic [bpc_pkg::BTN_IDX_BITS-1:0] button;
      logic [bpc_pkg::COUNT_BITS-1:0]   shorts;
      logic [bpc_pkg::COUNT_BITS-1:0]   longs;
      logic                             last;
   } event_word_type;

   class press_scoreboard;
      press_phase_type                phase [bpc_pkg::NUM_BUTTONS];
      logic [7:0]                     hold [bpc_pkg::NUM_BUTTONS];
      logic [TIMER_W-1:0]             timer [bpc_pkg::NUM_BUTTONS];
      logic [bpc_pkg::COUNT_BITS-1:0] shorts [bpc_pkg::NUM_BUTTONS];
      logic [bpc_pkg::COUNT_BITS-1:0] longs [bpc_pkg::NUM_BUTTONS];
      bit                             in_win [bpc_pkg::NUM_BUTTONS];
      bit                             closed [bpc_pkg::NUM_BUTTONS];
      bit                             sent [bpc_pkg::NUM_BUTTONS];
      bpc_pkg::cfg_regs_type          regs;
      event_word_type                 pending [$];
      int                             errors;

      function new();
         regs.window_ticks   = bpc_pkg::WINDOW_TICKS_RESET;
         regs.long_threshold = bpc_pkg::LONG_THRESHOLD_RESET;
         regs.short_limits   = bpc_pkg::SHORT_LIMITS_RESET;
         regs.long_limits    = bpc_pkg::LONG_LIMITS_RESET;
         errors = 0;
         for (int b = 0; b < bpc_pkg::NUM_BUTTONS; b++) clear_lane(b);
      endfunction

      function void write_reg(logic [bpc_pkg::CSR_IDX_BITS-1:0] idx,
                              logic [bpc_pkg::CSR_DATA_BITS-1:0] value);
         case (idx)
            bpc_pkg::REG_WINDOW_TICKS:   regs.window_ticks = value;
            bpc_pkg::REG_LONG_THRESHOLD: regs.long_threshold = value[7:0];
            bpc_pkg::REG_SHORT_LIMITS:   regs.short_limits = value;
            bpc_pkg::REG_LONG_LIMITS:    regs.long_limits = value;
            default: ;
         endcase
      endfunction

      function void clear_lane(int b);
         phase[b]  = PH_UP;
         hold[b]   = '0;
         timer[b]  = '0;
         shorts[b] = '0;
         longs[b]  = '0;
         in_win[b] = 1'b0;
         closed[b] = 1'b0;
         sent[b]   = 1'b0;
      endfunction

      function void close_window(int b);
         closed[b] = 1'b1;
         in_win[b] = 1'b0;
         timer[b]  = '0;
      endfunction

      function void scan(int b, bit pressed);
         case (phase[b])
            PH_UP: begin
               if (pressed) begin
                  phase[b] = PH_DOWN;
                  hold[b] = '0;
                  if (!in_win[b]) begin
                     in_win[b] = 1'b1;
                     timer[b] = regs.window_ticks[TIMER_W-1:0];
                  end
               end
            end
            PH_DOWN: begin
               timer[b] = timer[b] + 1'b1;
               if (pressed) begin
                  if (hold[b] < regs.long_threshold) hold[b] = hold[b] + 1'b1;
                  else phase[b] = PH_AFTER_LONG;
               end else begin
                  phase[b] = PH_UP;
                  hold[b] = '0;
                  if (shorts[b] != bpc_pkg::COUNT_MAX) shorts[b] = shorts[b] + 1'b1;
                  if (shorts[b] >= regs.short_limits[4*b +: 4]) close_window(b);
               end
            end
            PH_AFTER_LONG: begin
               if (pressed) begin
                  timer[b] = timer[b] + 1'b1;
               end else begin
                  phase[b] = PH_UP;
                  hold[b] = '0;
                  if (longs[b] != bpc_pkg::COUNT_MAX) longs[b] = longs[b] + 1'b1;
                  if (longs[b] >= regs.long_limits[4*b +: 4]) close_window(b);
               end
            end
            default: ;
         endcase
      endfunction

      function void note_tick(logic [bpc_pkg::NUM_BUTTONS-1:0] mask);
         event_word_type w;
         event_word_type fresh [$];
         for (int b = 0; b < bpc_pkg::NUM_BUTTONS; b++) begin
            if (closed[b]) begin
               if (!sent[b]) begin
                  sent[b] = 1'b1;
                  timer[b] = regs.window_ticks[TIMER_W-1:0];
                  in_win[b] = 1'b0;
                  w.button = bpc_pkg::BTN_IDX_BITS'(b);
                  w.shorts = shorts[b];
                  w.longs = longs[b];
                  w.last = 1'b0;
                  fresh.push_back(w);
               end else if (timer[b] > 0) begin
                  timer[b] = timer[b] - 1'b1;
               end else begin
                  clear_lane(b);
               end
            end else if (in_win[b]) begin
               if (timer[b] > 0) begin
                  timer[b] = timer[b] - 1'b1;
                  scan(b, mask[b]);
               end else begin
                  closed[b] = 1'b1;
               end
            end else begin
               scan(b, mask[b]);
            end
         end
         if (fresh.size() > 0) begin
            w = fresh.pop_back();
            w.last = 1'b1;
            fresh.push_back(w);
         end
         foreach (fresh[i]) pending.push_back(fresh[i]);
      endfunction

      task report(string what);
         if (errors < MAX_PRINTED) $display("ERROR at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_word(event_word_type got);
         event_word_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected word: button %0d short %0d long %0d last %0d",
                             got.button, got.shorts, got.longs, got.last));
         end else begin
            want = pending.pop_front();
            if (got.button !== want.button)
               report($sformatf("button_index got %0d want %0d", got.button, want.button));
            if (got.shorts !== want.shorts)
               report($sformatf("short_presses got %0d want %0d (button %0d)",
                                got.shorts, want.shorts, want.button));
            if (got.longs !== want.longs)
               report($sformatf("long_presses got %0d want %0d (button %0d)",
                                got.longs, want.longs, want.button));
            if (got.last !== want.last)
               report($sformatf("last got %0d want %0d (button %0d)",
                                got.last, want.last, want.button));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   press_scoreboard sb;
   bit quiet = 1'b0;
   int rsp_stall = 0;
   int cycles = 0;
   bit level [bpc_pkg::NUM_BUTTONS];
   int run_left [bpc_pkg::NUM_BUTTONS];
   logic [bpc_pkg::NUM_BUTTONS-1:0] directed [25] = '{
      4'hF, 4'h0, 4'h1, 4'h1, 4'h1, 4'h1, 4'h0, 4'h3, 4'h0, 4'h2, 4'h0, 4'h0, 4'h0,
      4'h8, 4'h8, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h4, 4'hF};

   bpc_req_if req_chan ();
   bpc_rsp_if rsp_chan ();
   bpc_csr_if csr_chan ();

   button_press_pattern_classifier_core #(.TIMER_BITS(TIMER_W)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // event word sink: random stall per word
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      event_word_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.button = rsp_chan.button_index;
         got.shorts = rsp_chan.short_presses;
         got.longs  = rsp_chan.long_presses;
         got.last   = rsp_chan.last;
         sb.check_word(got);
         rsp_stall = quiet ? 0 : $urandom_range(0, 17);
      end
   end

   // buttons hold their level for random runs, with some noise ticks
   function logic [bpc_pkg::NUM_BUTTONS-1:0] next_mask();
      logic [bpc_pkg::NUM_BUTTONS-1:0] m;
      int span;
      if ($urandom_range(0, 9) == 0) return bpc_pkg::NUM_BUTTONS'($urandom);
      span = (sb.regs.long_threshold < 10) ? int'(sb.regs.long_threshold) + 4 : 12;
      for (int b = 0; b < bpc_pkg::NUM_BUTTONS; b++) begin
         if (run_left[b] == 0) begin
            level[b] = !level[b];
            if (level[b]) run_left[b] = $urandom_range(1, span);
            else if ($urandom_range(0, 3) == 0) run_left[b] = $urandom_range(1, 20);
            else run_left[b] = $urandom_range(1, 4);
         end
         run_left[b]--;
         m[b] = level[b];
      end
      return m;
   endfunction

   task send_tick(logic [bpc_pkg::NUM_BUTTONS-1:0] mask);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pressed_mask <= mask;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_tick(mask);
      @(negedge clock);
   endtask

   task settle(int extra);
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task write_csr(logic [bpc_pkg::CSR_IDX_BITS-1:0] idx,
                  logic [bpc_pkg::CSR_DATA_BITS-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
      sb.write_reg(idx, value);
      @(negedge clock);
   endtask

   task set_config(logic [15:0] window, logic [15:0] threshold, logic [15:0] short_lim,
                   logic [15:0] long_lim);
      write_csr(bpc_pkg::REG_WINDOW_TICKS, window);
      write_csr(bpc_pkg::REG_LONG_THRESHOLD, threshold);
      write_csr(bpc_pkg::REG_SHORT_LIMITS, short_lim);
      write_csr(bpc_pkg::REG_LONG_LIMITS, long_lim);
      csr_chan.valid <= 1'b0;
   endtask

   task run_phase(int count, bit calm);
      quiet = calm;
      for (int i = 0; i < count; i++) begin
         send_tick(next_mask());
         if (i == count / 2) settle(0);
      end
      settle(DRAIN_CYCLES);
   endtask

   initial begin
      sb = new();
      req_chan.valid <= 1'b0;
      req_chan.pressed_mask <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= bpc_pkg::REG_WINDOW_TICKS;
      csr_chan.data <= '0;
      for (int b = 0; b < bpc_pkg::NUM_BUTTONS; b++) begin
         level[b] = 1'b0;
         run_left[b] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // per-button short limits 3, 2, 1 and zero on button 3
      set_config(16'd4, 16'd2, 16'h0123, 16'h1111);
      foreach (directed[i]) send_tick(directed[i]);
      settle(DRAIN_CYCLES);

      // zero window, zero threshold, zero limits
      set_config(16'd0, 16'd0, 16'h0000, 16'h0000);
      run_phase(50, 1'b0);

      for (int k = 0; k < 4; k++) begin
         set_config(16'($urandom_range(1, 15)),
                    {8'($urandom), 8'($urandom_range(0, 6))},
                    16'($urandom), 16'($urandom));
         run_phase(50, k == 1);
      end

      write_csr(REG_UNUSED, 16'($urandom));
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_phase(50, 1'b0);

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
